// File: hdl/mphf_pkg.sv
// Package for the multi-plane half-space filter.
// Holds widths, register indexes, compare codes and shared types.
// No dependencies; every file that uses it refers to it by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package mphf_pkg;

    localparam int NUM_PLANES = 3;
    localparam int COORD_W    = 16;
    localparam int COEF_W     = 16;
    localparam int PROD_W     = 2 * COORD_W;
    localparam int SUM_W      = PROD_W + 2;
    localparam int FRAC_BITS  = 14;
    localparam int CNT_W      = 2;
    localparam int OPS_W      = 6;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    localparam logic [CFG_IDX_W-1:0] CFG_PLANE_COUNT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COMBINE_OR  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COMPARE_OPS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PLANE0      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PLANE1      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_PLANE2      = 3'd5;

    localparam logic [1:0] CMP_LT = 2'd0;
    localparam logic [1:0] CMP_LE = 2'd1;
    localparam logic [1:0] CMP_GE = 2'd2;
    localparam logic [1:0] CMP_GT = 2'd3;

    typedef struct packed {
        logic [COEF_W-1:0] threshold;
        logic [COEF_W-1:0] coef_z;
        logic [COEF_W-1:0] coef_y;
        logic [COEF_W-1:0] coef_x;
    } plane_t;

    typedef struct packed {
        logic [CNT_W-1:0]            plane_count;
        logic                        combine_or;
        logic [OPS_W-1:0]            compare_ops;
        plane_t [NUM_PLANES-1:0]     planes;
    } cfg_t;

    typedef struct packed {
        logic [NUM_PLANES-1:0][2:0][PROD_W-1:0] prod;
        logic                                   quality_ok;
        logic                                   last_vertex;
    } prod_stage_t;

    function automatic logic [NUM_PLANES-1:0] plane_enables(input logic [CNT_W-1:0] count);
        logic [NUM_PLANES-1:0] en;
        for (int p = 0; p < NUM_PLANES; p++) begin
            en[p] = (p < int'(count));
        end
        return en;
    endfunction

endpackage

`default_nettype wire

// File: hdl/mphf_ifs.sv
// Channel interfaces of the multi-plane half-space filter.
// Vertex requests, draw results and configuration writes; uses mphf_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface mphf_vertex_if;
    logic                              valid;
    logic                              ready;
    logic signed [mphf_pkg::COORD_W-1:0] vertex_x;
    logic signed [mphf_pkg::COORD_W-1:0] vertex_y;
    logic signed [mphf_pkg::COORD_W-1:0] vertex_z;
    logic                              quality_ok;
    logic                              last_vertex;

    modport source (output valid, vertex_x, vertex_y, vertex_z, quality_ok, last_vertex,
                    input ready);
    modport sink (input valid, vertex_x, vertex_y, vertex_z, quality_ok, last_vertex,
                  output ready);
endinterface

interface mphf_draw_if;
    logic valid;
    logic ready;
    logic draw_flag;

    modport source (output valid, draw_flag, input ready);
    modport sink (input valid, draw_flag, output ready);
endinterface

interface mphf_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [mphf_pkg::CFG_IDX_W-1:0]     index;
    logic [mphf_pkg::CFG_DATA_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: hdl/mphf_cfg.sv
// Configuration register file of the multi-plane half-space filter.
// Takes write requests on the configuration channel; uses mphf_pkg and mphf_ifs.
`timescale 1ns / 1ps
`default_nettype none

module mphf_cfg (
    input  wire logic      clk,
    input  wire logic      rst_n,
    mphf_cfg_if.sink       cfg,
    output mphf_pkg::cfg_t regs
);

    mphf_pkg::cfg_t regs_reg;
    mphf_pkg::cfg_t regs_next;

    assign cfg.ready = 1'b1;
    assign regs      = regs_reg;

    always_comb
    begin
        regs_next = regs_reg;
        if (cfg.valid)
        begin
            case (cfg.index)
                mphf_pkg::CFG_PLANE_COUNT:
                begin
                    regs_next.plane_count = cfg.data[mphf_pkg::CNT_W-1:0];
                end
                mphf_pkg::CFG_COMBINE_OR:
                begin
                    regs_next.combine_or = cfg.data[0];
                end
                mphf_pkg::CFG_COMPARE_OPS:
                begin
                    regs_next.compare_ops = cfg.data[mphf_pkg::OPS_W-1:0];
                end
                default:
                begin
                    for (int p = 0; p < mphf_pkg::NUM_PLANES; p++)
                    begin
                        if (cfg.index == mphf_pkg::CFG_IDX_W'(int'(mphf_pkg::CFG_PLANE0) + p))
                        begin
                            regs_next.planes[p] = cfg.data;
                        end
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg <= '0;
        end
        else
        begin
            regs_reg <= regs_next;
        end
    end

endmodule

`default_nettype wire

// File: hdl/mphf_front.sv
// Input register and product register of the multi-plane half-space filter.
// Forms every coefficient-coordinate product; uses mphf_pkg and mphf_ifs.
`timescale 1ns / 1ps
`default_nettype none

module mphf_front (
    input  wire logic             clk,
    input  wire logic             rst_n,
    mphf_vertex_if.sink           vertex,
    input  wire mphf_pkg::cfg_t   regs,
    input  wire logic             take,
    output logic                  stage_valid,
    output mphf_pkg::prod_stage_t stage
);

    logic                                 in_valid_reg;
    logic                                 in_valid_next;
    logic signed [mphf_pkg::COORD_W-1:0]  x_reg;
    logic signed [mphf_pkg::COORD_W-1:0]  y_reg;
    logic signed [mphf_pkg::COORD_W-1:0]  z_reg;
    logic                                 quality_reg;
    logic                                 last_reg;
    logic                                 prod_valid_reg;
    logic                                 prod_valid_next;
    mphf_pkg::prod_stage_t                prod_reg;
    mphf_pkg::prod_stage_t                prod_next;
    logic                                 prod_free;
    logic                                 in_go;
    logic                                 in_take;

    assign prod_free    = !prod_valid_reg || take;
    assign in_go        = in_valid_reg && prod_free;
    assign vertex.ready = !in_valid_reg || in_go;
    assign in_take      = vertex.valid && vertex.ready;

    assign stage_valid = prod_valid_reg;
    assign stage       = prod_reg;

    always_comb
    begin
        in_valid_next = in_take || (in_valid_reg && !in_go);
        if (in_go)
        begin
            prod_valid_next = 1'b1;
        end
        else if (take)
        begin
            prod_valid_next = 1'b0;
        end
        else
        begin
            prod_valid_next = prod_valid_reg;
        end
    end

    always_comb
    begin
        prod_next.quality_ok  = quality_reg;
        prod_next.last_vertex = last_reg;
        for (int p = 0; p < mphf_pkg::NUM_PLANES; p++)
        begin
            prod_next.prod[p][0] = mphf_pkg::PROD_W'(
                $signed(regs.planes[p].coef_x) * x_reg);
            prod_next.prod[p][1] = mphf_pkg::PROD_W'(
                $signed(regs.planes[p].coef_y) * y_reg);
            prod_next.prod[p][2] = mphf_pkg::PROD_W'(
                $signed(regs.planes[p].coef_z) * z_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            prod_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg   <= in_valid_next;
            prod_valid_reg <= prod_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            x_reg       <= vertex.vertex_x;
            y_reg       <= vertex.vertex_y;
            z_reg       <= vertex.vertex_z;
            quality_reg <= vertex.quality_ok;
            last_reg    <= vertex.last_vertex;
        end
        if (in_go)
        begin
            prod_reg <= prod_next;
        end
    end

endmodule

`default_nettype wire

// File: hdl/mphf_eval.sv
// Plane tests, running pass bits and draw result register of the filter.
// Sums the products, compares with the thresholds; uses mphf_pkg and mphf_ifs.
`timescale 1ns / 1ps
`default_nettype none

module mphf_eval (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire mphf_pkg::cfg_t        regs,
    input  wire logic                  stage_valid,
    input  wire mphf_pkg::prod_stage_t stage,
    output logic                       take,
    mphf_draw_if.source                draw
);

    logic [mphf_pkg::NUM_PLANES-1:0] pass_bits_reg;
    logic [mphf_pkg::NUM_PLANES-1:0] pass_bits_next;
    logic                            out_valid_reg;
    logic                            out_valid_next;
    logic                            flag_reg;
    logic [mphf_pkg::NUM_PLANES-1:0] enables;
    logic [mphf_pkg::NUM_PLANES-1:0] vertex_pass;
    logic [mphf_pkg::NUM_PLANES-1:0] bits_now;
    logic                            out_free;
    logic                            go;
    logic                            finish;
    logic                            all_pass;
    logic                            any_pass;
    logic                            draw_now;

    assign out_free = !out_valid_reg || draw.ready;
    assign take     = !stage.last_vertex || out_free;
    assign go       = stage_valid && take;
    assign finish   = go && stage.last_vertex;

    assign draw.valid     = out_valid_reg;
    assign draw.draw_flag = flag_reg;

    assign enables = mphf_pkg::plane_enables(regs.plane_count);

    always_comb
    begin
        logic signed [mphf_pkg::SUM_W-1:0] sum;
        logic signed [mphf_pkg::SUM_W-1:0] limit;
        logic [1:0]                         op;
        for (int p = 0; p < mphf_pkg::NUM_PLANES; p++)
        begin
            sum = mphf_pkg::SUM_W'($signed(stage.prod[p][0]))
                + mphf_pkg::SUM_W'($signed(stage.prod[p][1]))
                + mphf_pkg::SUM_W'($signed(stage.prod[p][2]));
            limit = mphf_pkg::SUM_W'($signed(regs.planes[p].threshold)) <<< mphf_pkg::FRAC_BITS;
            op = regs.compare_ops[2*p +: 2];
            case (op)
                mphf_pkg::CMP_LT: vertex_pass[p] = (sum < limit);
                mphf_pkg::CMP_LE: vertex_pass[p] = (sum <= limit);
                mphf_pkg::CMP_GE: vertex_pass[p] = (sum >= limit);
                default:          vertex_pass[p] = (sum > limit);
            endcase
        end
    end

    always_comb
    begin
        bits_now = pass_bits_reg & ~(enables & ~vertex_pass);
        all_pass = &(bits_now | ~enables);
        any_pass = |(bits_now & enables);
        if (!stage.quality_ok)
        begin
            draw_now = 1'b0;
        end
        else if (enables == '0)
        begin
            draw_now = 1'b1;
        end
        else
        begin
            draw_now = regs.combine_or ? any_pass : all_pass;
        end

        if (finish)
        begin
            pass_bits_next = '1;
        end
        else if (go)
        begin
            pass_bits_next = bits_now;
        end
        else
        begin
            pass_bits_next = pass_bits_reg;
        end

        if (finish)
        begin
            out_valid_next = 1'b1;
        end
        else if (draw.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pass_bits_reg <= '1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pass_bits_reg <= pass_bits_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (finish)
        begin
            flag_reg <= draw_now;
        end
    end

endmodule

`default_nettype wire

// File: hdl/multi_plane_halfspace_filter.sv
// Top level of the multi-plane half-space filter.
// Instantiates mphf_cfg, mphf_front and mphf_eval; uses mphf_pkg and mphf_ifs.
//
// Usage:
// Vertex requests arrive on the vertex channel, one per vertex of a mesh
// element, the final one marked by last_vertex. Every vertex is tested
// against each active plane, and one draw result per element leaves on the
// draw channel after its last vertex. Non-final vertices give no result.
// The configuration channel is always ready and writes one register per
// request; write it only while no element is in flight.
// Throughput is one vertex per cycle unless a stalled draw result backs up
// the pipeline. A last vertex passes the input register, the product register
// and the result register before its draw result shows. Nine 16 by 16
// multipliers form the products ahead of the product register; the sums and
// threshold compares lie between the product and the result register.
// Reset clears the valid and configuration registers, empties the pipeline
// and sets all running plane pass bits. When the receiver stalls, the result
// register holds its flag; vertices keep flowing until a second element
// result is waiting, and then the vertex channel drops ready.
`timescale 1ns / 1ps
`default_nettype none

module multi_plane_halfspace_filter (
    input  wire logic   clk,
    input  wire logic   rst_n,
    mphf_vertex_if.sink vertex,
    mphf_draw_if.source draw,
    mphf_cfg_if.sink    cfg
);

    mphf_pkg::cfg_t        regs;
    mphf_pkg::prod_stage_t stage;
    logic                  stage_valid;
    logic                  take;

    mphf_cfg u_cfg (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (regs)
    );

    mphf_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .vertex      (vertex),
        .regs        (regs),
        .take        (take),
        .stage_valid (stage_valid),
        .stage       (stage)
    );

    mphf_eval u_eval (
        .clk         (clk),
        .rst_n       (rst_n),
        .regs        (regs),
        .stage_valid (stage_valid),
        .stage       (stage),
        .take        (take),
        .draw        (draw)
    );

endmodule

`default_nettype wire

// File: hdl/mphf_checker.sv
// Port checker for the multi-plane half-space filter, bound to the top level.
// Watches the vertex, draw and configuration handshakes; no other dependencies.
`timescale 1ns / 1ps
`default_nettype none

module mphf_checker (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic vertex_ready,
    input wire logic draw_valid,
    input wire logic draw_ready,
    input wire logic draw_flag,
    input wire logic cfg_valid,
    input wire logic cfg_ready
);

    // The vertex channel may only back up when a result is stuck at the output.
    assert property (@(posedge clk) disable iff (!rst_n)
        !vertex_ready |-> (draw_valid && !draw_ready))
        else $error("vertex channel stalled without a blocked result");

    assert property (@(posedge clk) disable iff (!rst_n)
        (draw_valid && !draw_ready) |=> draw_valid)
        else $error("draw result withdrawn while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        (draw_valid && !draw_ready) |=> $stable(draw_flag))
        else $error("draw flag changed while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("configuration write refused");

endmodule

bind multi_plane_halfspace_filter mphf_checker u_mphf_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .vertex_ready (vertex.ready),
    .draw_valid   (draw.valid),
    .draw_ready   (draw.ready),
    .draw_flag    (draw.draw_flag),
    .cfg_valid    (cfg.valid),
    .cfg_ready    (cfg.ready)
);

`default_nettype wire
